// ===== rtl/core/conv3x3_zero_padded_unit_assert.svh =====
// ----------------------------------------------------------------------------
// conv3x3 assertion macros
// Concurrent check wrappers used by the conv3x3 core modules. Define
// ASSERT_OFF to compile the checks away.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_ZERO_PADDED_UNIT_ASSERT_SVH
`define CONV3X3_ZERO_PADDED_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define CV3_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("conv3x3 assertion failed");

// condition must never be true outside reset
`define CV3_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("conv3x3 forbidden condition seen");

`else

`define CV3_ASSERT(lbl, clk, rst_n, prop)
`define CV3_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/cv3_pkg.sv =====
// ----------------------------------------------------------------------------
// cv3_pkg
// Shared constants and types of the 3x3 zero padded correlation core.
// ----------------------------------------------------------------------------
`default_nettype none

package cv3_pkg;

    // frame geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;

    // line memory: one entry per column, two stacked pixels
    localparam int LINE_W     = 2 * PIXEL_BITS;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int COEF_W     = 8;

    // arithmetic
    localparam int PROD_W     = PIXEL_BITS + 1 + COEF_W;
    localparam int FILT_W     = 20;

    // job queue between window and result sequencer
    localparam int JOB_DEPTH  = 4;
    localparam int PTR_W      = $clog2(JOB_DEPTH);
    localparam int CNT_W      = $clog2(JOB_DEPTH + 1);

    // result kinds per input: centre, row end, last row, last row end
    localparam int N_KIND     = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

    // reset values
    localparam logic [CFG_DATA_W-1:0] KERNEL_TOP_RST = 24'h010201;
    localparam logic [CFG_DATA_W-1:0] KERNEL_MID_RST = 24'h000000;
    localparam logic [CFG_DATA_W-1:0] KERNEL_BOT_RST = 24'hFFFEFF;
    localparam int                    DIM_RST        = 3;

    // window[row][col], row 0 oldest, col 0 leftmost
    typedef logic [2:0][2:0][PIXEL_BITS-1:0] t_win;

    // kernel[row][col], signed coefficients
    typedef logic [2:0][2:0][COEF_W-1:0] t_kernel;

    // one input's worth of work
    typedef struct packed {
        t_win              win;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [N_KIND-1:0] mask;
    } t_job;

    // one result ready for the multiply-accumulate pipe
    typedef struct packed {
        t_win             px;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             frame_done;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/core/cv3_line_ram.sv =====
// ----------------------------------------------------------------------------
// cv3_line_ram
// Line memory, one entry per column holding the two previous rows' pixels.
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_line_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [cv3_pkg::COL_W-1:0]     i_wr_addr,
    input  wire logic [cv3_pkg::LINE_W-1:0]    i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [cv3_pkg::COL_W-1:0]     i_rd_addr,
    output logic      [cv3_pkg::LINE_W-1:0]    o_rd_data
);

    logic [cv3_pkg::LINE_W-1:0] mem [cv3_pkg::MAX_WIDTH];
    logic [cv3_pkg::LINE_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/cv3_front.sv =====
// ----------------------------------------------------------------------------
// cv3_front
// Pixel intake: position counters, line memory read-modify-write with
// forwarding, 3x3 window shift and job formation.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic [cv3_pkg::PIXEL_BITS-1:0]    i_pixel,
    output logic                                   o_stall,
    input  wire logic                              i_restart,
    input  wire logic [cv3_pkg::COL_W-1:0]         i_w_last,
    input  wire logic [cv3_pkg::ROW_W-1:0]         i_h_last,
    input  wire logic [cv3_pkg::CNT_W-1:0]         i_q_count,
    output logic                                   o_push,
    output cv3_pkg::t_job                          o_job
);

    logic                              accept;
    logic [cv3_pkg::CNT_W-1:0]         load;

    logic [cv3_pkg::ROW_W-1:0]         r_row;
    logic [cv3_pkg::COL_W-1:0]         r_col;

    logic                              r_s1_valid;
    logic [cv3_pkg::PIXEL_BITS-1:0]    r_s1_px;
    logic [cv3_pkg::ROW_W-1:0]         r_s1_row;
    logic [cv3_pkg::COL_W-1:0]         r_s1_col;

    logic                              r_wr_valid;
    logic [cv3_pkg::COL_W-1:0]         r_wr_addr;
    logic [cv3_pkg::LINE_W-1:0]        r_wr_data;

    logic [cv3_pkg::LINE_W-1:0]        ram_q;
    logic [cv3_pkg::LINE_W-1:0]        line_rd;
    logic [cv3_pkg::LINE_W-1:0]        line_wr;
    logic [cv3_pkg::PIXEL_BITS-1:0]    above1;
    logic [cv3_pkg::PIXEL_BITS-1:0]    above2;

    cv3_pkg::t_win                     r_win;
    cv3_pkg::t_win                     n_win;
    logic [cv3_pkg::N_KIND-1:0]        mask;

    // hold off requests while the job queue could overflow
    assign load    = i_q_count + cv3_pkg::CNT_W'(r_s1_valid);
    assign o_stall = load > cv3_pkg::CNT_W'(cv3_pkg::JOB_DEPTH - 2);
    assign accept  = i_valid && !o_stall;

    // position of the next request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (r_col == i_w_last) begin
                r_col <= '0;
                r_row <= (r_row == i_h_last) ? '0 : r_row + cv3_pkg::ROW_W'(1);
            end else begin
                r_col <= r_col + cv3_pkg::COL_W'(1);
            end
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wr_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_wr_valid <= r_s1_valid;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px  <= i_pixel;
            r_s1_row <= r_row;
            r_s1_col <= r_col;
        end
        r_wr_addr <= r_s1_col;
        r_wr_data <= line_wr;
    end

    cv3_line_ram u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (line_wr),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (ram_q)
    );

    // forward the write of the last cycle when the read hit the same column
    assign line_rd = (r_wr_valid && (r_wr_addr == r_s1_col)) ? r_wr_data : ram_q;
    assign above1  = line_rd[cv3_pkg::LINE_W-1:cv3_pkg::PIXEL_BITS];
    assign above2  = line_rd[cv3_pkg::PIXEL_BITS-1:0];
    assign line_wr = {r_s1_px, above1};

    // window shifts left by one column, new column from memory and input
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = above2;
        n_win[1][2] = above1;
        n_win[2][2] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    // which results this pixel releases
    always_comb begin
        mask[0] = (r_s1_row != '0) && (r_s1_col != '0);
        mask[1] = (r_s1_row != '0) && (r_s1_col == i_w_last);
        mask[2] = (r_s1_row == i_h_last) && (r_s1_col != '0);
        mask[3] = (r_s1_row == i_h_last) && (r_s1_col == i_w_last);
    end

    assign o_push     = r_s1_valid && (mask != '0);
    assign o_job.win  = n_win;
    assign o_job.row  = r_s1_row;
    assign o_job.col  = r_s1_col;
    assign o_job.mask = mask;

endmodule

`default_nettype wire

// ===== rtl/core/cv3_emit.sv =====
// ----------------------------------------------------------------------------
// cv3_emit
// Job queue and result sequencer: walks each job's result kinds, one per
// cycle if i_ready is high; selects and masks window taps per output position.
// ----------------------------------------------------------------------------
`default_nettype none
`include "conv3x3_zero_padded_unit_assert.svh"

module cv3_emit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  cv3_pkg::t_job                      i_job,
    output logic [cv3_pkg::CNT_W-1:0]          o_count,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output cv3_pkg::t_res                      o_res
);

    cv3_pkg::t_job                  r_q [cv3_pkg::JOB_DEPTH];
    logic [cv3_pkg::PTR_W-1:0]      r_wp;
    logic [cv3_pkg::PTR_W-1:0]      r_rp;
    logic [cv3_pkg::CNT_W-1:0]      r_count;
    logic [cv3_pkg::N_KIND-1:0]     r_done;

    cv3_pkg::t_job                  head;
    logic [cv3_pkg::N_KIND-1:0]     pending;
    logic [cv3_pkg::N_KIND-1:0]     pick;
    logic                           last;
    logic                           take;
    logic                           pop;
    logic                           sr;
    logic                           sc;
    logic [2:0]                     row_ok;
    logic [2:0]                     col_ok;

    assign head    = r_q[r_rp];
    assign pending = head.mask & ~r_done;
    assign pick    = pending & (~pending + cv3_pkg::N_KIND'(1));
    assign last    = (pending & ~pick) == '0;
    assign o_valid = r_count != '0;
    assign take    = o_valid && i_ready;
    assign pop     = take && last;
    assign o_count = r_count;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    // queue pointers and per-job progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
            r_done  <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + cv3_pkg::PTR_W'(1);
            end
            if (pop) begin
                r_rp   <= r_rp + cv3_pkg::PTR_W'(1);
                r_done <= '0;
            end else if (take) begin
                r_done <= r_done | pick;
            end
            r_count <= r_count + cv3_pkg::CNT_W'(i_push) - cv3_pkg::CNT_W'(pop);
        end
    end

    // row / column shift of the output centre inside the window
    assign sr = pick[2] | pick[3];
    assign sc = pick[1] | pick[3];

    // neighbours inside the frame: top, centre, bottom and left, centre, right
    always_comb begin
        row_ok[0] = sr ? (head.row != '0) : (head.row > cv3_pkg::ROW_W'(1));
        row_ok[1] = 1'b1;
        row_ok[2] = !sr;
        col_ok[0] = sc ? (head.col != '0) : (head.col > cv3_pkg::COL_W'(1));
        col_ok[1] = 1'b1;
        col_ok[2] = !sc;
    end

    // tap selection with zero padding
    always_comb begin
        logic [1:0] ri;
        logic [1:0] cj;
        ri = '0;
        cj = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ri = (sr && (i < 2)) ? 2'(i + 1) : 2'(i);
                cj = (sc && (j < 2)) ? 2'(j + 1) : 2'(j);
                o_res.px[i][j] = (row_ok[i] && col_ok[j]) ? head.win[ri][cj] : '0;
            end
        end
    end

    assign o_res.row        = sr ? head.row : head.row - cv3_pkg::ROW_W'(1);
    assign o_res.col        = sc ? head.col : head.col - cv3_pkg::COL_W'(1);
    assign o_res.last       = last;
    assign o_res.frame_done = pick[3];

    // flow control keeps the queue short of full
    `CV3_NEVER(a_push_full, i_clk, i_rst_n, i_push && (r_count == cv3_pkg::CNT_W'(cv3_pkg::JOB_DEPTH)))
    // progress bits only ever cover kinds the head job asked for
    `CV3_ASSERT(a_done_in_mask, i_clk, i_rst_n, (r_count != '0) |-> ((r_done & ~head.mask) == '0))
    // an empty queue carries no partial progress
    `CV3_ASSERT(a_empty_clean, i_clk, i_rst_n, (r_count == '0) |-> (r_done == '0))

endmodule

`default_nettype wire

// ===== rtl/core/cv3_mac.sv =====
// ----------------------------------------------------------------------------
// cv3_mac
// Multiply-accumulate pipe: nine products, three row sums, final sum into
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_mac (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  cv3_pkg::t_res                              i_res,
    input  cv3_pkg::t_kernel                           i_kernel,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [cv3_pkg::FILT_W-1:0]          o_filtered,
    output logic        [cv3_pkg::ROW_W-1:0]           o_out_row,
    output logic        [cv3_pkg::COL_W-1:0]           o_out_col,
    output logic                                       o_run_last,
    output logic                                       o_frame_done
);

    logic                                  p_ready;
    logic                                  q_ready;
    logic                                  out_ready;

    logic signed [cv3_pkg::PROD_W-1:0]     n_prod [3][3];
    logic signed [cv3_pkg::FILT_W-1:0]     n_rsum [3];
    logic signed [cv3_pkg::FILT_W-1:0]     n_total;

    logic                                  r_p_valid;
    logic signed [cv3_pkg::PROD_W-1:0]     r_p_prod [3][3];
    logic [cv3_pkg::ROW_W-1:0]             r_p_row;
    logic [cv3_pkg::COL_W-1:0]             r_p_col;
    logic                                  r_p_last;
    logic                                  r_p_done;

    logic                                  r_q_valid;
    logic signed [cv3_pkg::FILT_W-1:0]     r_q_rsum [3];
    logic [cv3_pkg::ROW_W-1:0]             r_q_row;
    logic [cv3_pkg::COL_W-1:0]             r_q_col;
    logic                                  r_q_last;
    logic                                  r_q_done;

    logic                                  r_o_valid;
    logic signed [cv3_pkg::FILT_W-1:0]     r_o_filtered;
    logic [cv3_pkg::ROW_W-1:0]             r_o_row;
    logic [cv3_pkg::COL_W-1:0]             r_o_col;
    logic                                  r_o_last;
    logic                                  r_o_done;

    // backpressure chain
    assign out_ready = !r_o_valid || !i_stall;
    assign q_ready   = !r_q_valid || out_ready;
    assign p_ready   = !r_p_valid || q_ready;
    assign o_ready   = p_ready;

    // unsigned pixel times signed coefficient
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[i][j] = $signed({1'b0, i_res.px[i][j]}) * $signed(i_kernel[i][j]);
            end
        end
    end

    // row sums
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rsum[i] = cv3_pkg::FILT_W'(r_p_prod[i][0]) + cv3_pkg::FILT_W'(r_p_prod[i][1])
                      + cv3_pkg::FILT_W'(r_p_prod[i][2]);
        end
    end

    assign n_total = r_q_rsum[0] + r_q_rsum[1] + r_q_rsum[2];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_q_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (p_ready) begin
                r_p_valid <= i_valid;
            end
            if (q_ready) begin
                r_q_valid <= r_p_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_q_valid;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (p_ready && i_valid) begin
            r_p_prod <= n_prod;
            r_p_row  <= i_res.row;
            r_p_col  <= i_res.col;
            r_p_last <= i_res.last;
            r_p_done <= i_res.frame_done;
        end
        if (q_ready && r_p_valid) begin
            r_q_rsum <= n_rsum;
            r_q_row  <= r_p_row;
            r_q_col  <= r_p_col;
            r_q_last <= r_p_last;
            r_q_done <= r_p_done;
        end
        if (out_ready && r_q_valid) begin
            r_o_filtered <= n_total;
            r_o_row      <= r_q_row;
            r_o_col      <= r_q_col;
            r_o_last     <= r_q_last;
            r_o_done     <= r_q_done;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_filtered   = r_o_filtered;
    assign o_out_row    = r_o_row;
    assign o_out_col    = r_o_col;
    assign o_run_last   = r_o_last;
    assign o_frame_done = r_o_done;

endmodule

`default_nettype wire

// ===== rtl/core/conv3x3_zero_padded_unit.sv =====
// ----------------------------------------------------------------------------
// conv3x3_zero_padded_unit: streaming 3x3 correlation with zero padding
// Path to a result: stage 1 register, job queue, product, row-sum and output
// registers. Throughput: 1 pixel per cycle while o_stall is low; the output
// register issues one result per cycle while i_stall is low.
// Reset: synchronous; kernel, size and counters to defaults, line memory kept.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_zero_padded_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // pixel requests
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [cv3_pkg::PIXEL_BITS-1:0]        i_pixel,
    // result requests
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [cv3_pkg::FILT_W-1:0]          o_filtered,
    output logic        [cv3_pkg::ROW_W-1:0]           o_out_row,
    output logic        [cv3_pkg::COL_W-1:0]           o_out_col,
    output logic                                       o_run_last,
    output logic                                       o_frame_done,
    // configuration writes
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [cv3_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [cv3_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic [cv3_pkg::CFG_DATA_W-1:0]    r_k_top;
    logic [cv3_pkg::CFG_DATA_W-1:0]    r_k_mid;
    logic [cv3_pkg::CFG_DATA_W-1:0]    r_k_bot;
    logic [cv3_pkg::COL_W-1:0]         r_w_last;
    logic [cv3_pkg::ROW_W-1:0]         r_h_last;
    logic [cv3_pkg::COL_W-1:0]         n_w_last;
    logic [cv3_pkg::ROW_W-1:0]         n_h_last;
    logic [cv3_pkg::DIM_W-1:0]         dim;
    logic                              restart;
    cv3_pkg::t_kernel                  kernel;

    logic                              push;
    cv3_pkg::t_job                     job;
    logic [cv3_pkg::CNT_W-1:0]         q_count;
    logic                              res_valid;
    logic                              res_ready;
    cv3_pkg::t_res                     res;

    // clamp a written size to 1..max and keep its last index
    assign dim = i_cfg_data[cv3_pkg::DIM_W-1:0];

    always_comb begin
        if (dim == '0) begin
            n_w_last = '0;
            n_h_last = '0;
        end else begin
            n_w_last = (dim > cv3_pkg::DIM_W'(cv3_pkg::MAX_WIDTH))
                     ? cv3_pkg::COL_W'(cv3_pkg::MAX_WIDTH - 1)
                     : cv3_pkg::COL_W'(dim - cv3_pkg::DIM_W'(1));
            n_h_last = (dim > cv3_pkg::DIM_W'(cv3_pkg::MAX_HEIGHT))
                     ? cv3_pkg::ROW_W'(cv3_pkg::MAX_HEIGHT - 1)
                     : cv3_pkg::ROW_W'(dim - cv3_pkg::DIM_W'(1));
        end
    end

    // a size write restarts the frame
    assign restart = i_cfg_wr_en && ((i_cfg_index == cv3_pkg::CFG_FRAME_WIDTH)
                                  || (i_cfg_index == cv3_pkg::CFG_FRAME_HEIGHT));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_top  <= cv3_pkg::KERNEL_TOP_RST;
            r_k_mid  <= cv3_pkg::KERNEL_MID_RST;
            r_k_bot  <= cv3_pkg::KERNEL_BOT_RST;
            r_w_last <= cv3_pkg::COL_W'(cv3_pkg::DIM_RST - 1);
            r_h_last <= cv3_pkg::ROW_W'(cv3_pkg::DIM_RST - 1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                cv3_pkg::CFG_KERNEL_TOP: begin
                    r_k_top <= i_cfg_data;
                end
                cv3_pkg::CFG_KERNEL_MID: begin
                    r_k_mid <= i_cfg_data;
                end
                cv3_pkg::CFG_KERNEL_BOT: begin
                    r_k_bot <= i_cfg_data;
                end
                cv3_pkg::CFG_FRAME_WIDTH: begin
                    r_w_last <= n_w_last;
                end
                cv3_pkg::CFG_FRAME_HEIGHT: begin
                    r_h_last <= n_h_last;
                end
                default: begin
                end
            endcase
        end
    end

    assign kernel[0] = r_k_top;
    assign kernel[1] = r_k_mid;
    assign kernel[2] = r_k_bot;

    cv3_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_pixel   (i_pixel),
        .o_stall   (o_stall),
        .i_restart (restart),
        .i_w_last  (r_w_last),
        .i_h_last  (r_h_last),
        .i_q_count (q_count),
        .o_push    (push),
        .o_job     (job)
    );

    cv3_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_count (q_count),
        .o_valid (res_valid),
        .i_ready (res_ready),
        .o_res   (res)
    );

    cv3_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (res_valid),
        .o_ready      (res_ready),
        .i_res        (res),
        .i_kernel     (kernel),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_filtered   (o_filtered),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done)
    );

endmodule

`default_nettype wire

// ===== dv/conv3x3_zero_padded_unit_tb.sv =====
// ----------------------------------------------------------------------------
// conv3x3_zero_padded_unit_tb
// Self-checking bench for the streaming 3x3 zero padded correlation unit.
// Pixels go in through the valid/stall request port and the frame geometry
// and kernel are changed through the register port whenever the unit is
// quiet. A local model of the line buffers, window and raster counters
// works out every filtered pixel, and each result coming out is compared
// with the oldest one still outstanding. A short table of hand-picked
// requests runs first, then fixed and then random settings and pixel streams.
// ----------------------------------------------------------------------------
module conv3x3_zero_padded_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cv3_pkg::*;

    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SMALL_ITEMS    = 120;
    localparam int MAX_LOGGED     = 40;

    // indexes past the register list, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic signed [FILT_W-1:0] filtered;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic                     last;
        logic                     frame_done;
    } conv_result_t;

    typedef enum logic [1:0] {PIX_ANY, PIX_EDGE, PIX_FULL} pix_mode_e;
    typedef enum logic {ROW_CFG, ROW_PIXEL} dir_kind_e;

    typedef struct {
        dir_kind_e               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic [PIXEL_BITS-1:0]   px;
        bit                      typed;
        int                      n_typed;
        conv_result_t            res;
    } dir_row_t;

    // unit ports
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     o_stall;
    logic [PIXEL_BITS-1:0]    i_pixel     = '0;
    logic                     o_valid;
    logic                     i_stall     = 1'b0;
    logic signed [FILT_W-1:0] o_filtered;
    logic [ROW_W-1:0]         o_out_row;
    logic [COL_W-1:0]         o_out_col;
    logic                     o_run_last;
    logic                     o_frame_done;
    logic                     i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data  = '0;

    // local copy of the filter state
    logic [CFG_DATA_W-1:0] kern_rows [3];
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [PIXEL_BITS-1:0] line_mem [2][MAX_WIDTH];
    logic [PIXEL_BITS-1:0] win [3][3];
    int                    row_pos;
    int                    col_pos;

    // results of the latest pixel, and everything still outstanding
    conv_result_t fresh [4];
    int           fresh_n;
    conv_result_t pending_results [$];
    dir_row_t     stim_table [$];

    // run bookkeeping
    int mismatches   = 0;
    int pixels_sent  = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int phases_run   = 0;
    int quiet_cycles = 0;
    bit idle_on      = 1'b1;
    bit hold_req     = 1'b0;
    int hold_cnt     = 0;
    int stall_left   = 0;

    conv3x3_zero_padded_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel      (i_pixel),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_filtered   (o_filtered),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // zero means one, oversize clamps to the maximum
    function automatic int eff_dim(logic [DIM_W-1:0] v, int lim);
        if (v == 0) return 1;
        if (int'(v) > lim) return lim;
        return int'(v);
    endfunction

    function automatic int coef(int kr, int kc);
        return int'($signed(kern_rows[kr][kc*COEF_W +: COEF_W]));
    endfunction

    // sum of products at (orow, ocol); window spans rows r-2..r, cols c-2..c
    function automatic void add_result(int orow, int ocol, int r, int c, int w, int h);
        int sum;
        int di;
        int dj;
        int nr;
        int nc;
        int wi;
        int wj;
        sum = 0;
        for (di = 0; di < 3; di++) begin
            for (dj = 0; dj < 3; dj++) begin
                nr = orow + di - 1;
                nc = ocol + dj - 1;
                wi = nr - (r - 2);
                wj = nc - (c - 2);
                if (nr >= 0 && nr < h && nc >= 0 && nc < w &&
                    wi >= 0 && wi <= 2 && wj >= 0 && wj <= 2) begin
                    sum += int'(win[wi][wj]) * coef(di, dj);
                end
            end
        end
        fresh[fresh_n].filtered   = sum[FILT_W-1:0];
        fresh[fresh_n].row        = orow[ROW_W-1:0];
        fresh[fresh_n].col        = ocol[COL_W-1:0];
        fresh[fresh_n].last       = 1'b0;
        fresh[fresh_n].frame_done = (orow == h - 1 && ocol == w - 1);
        fresh_n++;
    endfunction

    // advance the local state by one pixel and collect what it releases
    function automatic void predict_pixel(logic [PIXEL_BITS-1:0] px);
        int w;
        int h;
        int r;
        int c;
        logic [PIXEL_BITS-1:0] above2;
        logic [PIXEL_BITS-1:0] above1;
        w = eff_dim(width_reg, MAX_WIDTH);
        h = eff_dim(height_reg, MAX_HEIGHT);
        fresh_n = 0;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        r = row_pos;
        c = col_pos;

        // line buffers: row r lives in slot r mod 2
        above2 = line_mem[r % 2][c];
        above1 = line_mem[(r + 1) % 2][c];
        line_mem[r % 2][c] = px;

        // shift window left, new column on the right
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = above2;
        win[1][2] = above1;
        win[2][2] = px;

        // centre behind the input, row end flush, last row flush
        if (r >= 1 && c >= 1) add_result(r - 1, c - 1, r, c, w, h);
        if (r >= 1 && c == w - 1) add_result(r - 1, w - 1, r, c, w, h);
        if (r == h - 1) begin
            if (c >= 1) add_result(r, c - 1, r, c, w, h);
            if (c == w - 1) add_result(r, w - 1, r, c, w, h);
        end
        if (fresh_n > 0) fresh[fresh_n - 1].last = 1'b1;

        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    // register write seen by the local state; size writes restart the frame
    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_KERNEL_TOP, CFG_KERNEL_MID, CFG_KERNEL_BOT: begin
                kern_rows[idx] = data;
            end
            CFG_FRAME_WIDTH: begin
                width_reg = data[DIM_W-1:0];
                row_pos   = 0;
                col_pos   = 0;
            end
            CFG_FRAME_HEIGHT: begin
                height_reg = data[DIM_W-1:0];
                row_pos    = 0;
                col_pos    = 0;
            end
            default: begin
            end
        endcase
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_idle(int busy_pct, int long_hi);
        int roll;
        if (!idle_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < busy_pct) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, long_hi);
    endfunction

    function automatic logic [PIXEL_BITS-1:0] pick_pixel(pix_mode_e mode);
        case (mode)
            PIX_FULL: return '1;
            PIX_EDGE: return $urandom_range(0, 1) ? '1 : '0;
            default:  return PIXEL_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_kernel();
        case ($urandom_range(0, 9))
            0:       return 24'h7F7F7F;
            1:       return 24'h808080;
            2:       return 24'h000000;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // size word with junk above the used bits
    function automatic logic [CFG_DATA_W-1:0] dim_word(logic [DIM_W-1:0] v);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        word[DIM_W-1:0] = v;
        return word;
    endfunction

    // directed table rows
    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        dir_row_t row;
        row = '{ROW_CFG, idx, data, '0, 1'b0, 0, '0};
        stim_table.push_back(row);
    endfunction

    function automatic void add_pixel(logic [PIXEL_BITS-1:0] px);
        dir_row_t row;
        row = '{ROW_PIXEL, '0, '0, px, 1'b0, 0, '0};
        stim_table.push_back(row);
    endfunction

    function automatic void add_typed(logic [PIXEL_BITS-1:0] px, int n, int filt,
                                      int orow, int ocol, bit done);
        dir_row_t row;
        row = '{ROW_PIXEL, '0, '0, px, 1'b1, n, '0};
        row.res.filtered   = filt[FILT_W-1:0];
        row.res.row        = orow[ROW_W-1:0];
        row.res.col        = ocol[COL_W-1:0];
        row.res.last       = 1'b1;
        row.res.frame_done = done;
        stim_table.push_back(row);
    endfunction

    task automatic note_mismatch(string what, int got, int want);
        mismatches++;
        // keep the log short on a badly broken build
        if (mismatches <= MAX_LOGGED) begin
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        end
    endtask

    // wait until every result is back and the pipe has emptied
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_cfg(idx, data);
        cfg_writes++;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // one pixel request; expected results queued once it is taken
    task automatic offer_pixel(logic [PIXEL_BITS-1:0] px, bit typed, int n_typed,
                               conv_result_t typed_res);
        int gap;
        gap = pick_idle(65, 30);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_pixel(px);
        pixels_sent++;
        if (typed) begin
            if (n_typed != 0) pending_results.push_back(typed_res);
        end else begin
            for (int k = 0; k < fresh_n; k++) pending_results.push_back(fresh[k]);
        end
    endtask

    // one setting: chosen registers written while quiet, then a pixel stream
    task automatic run_phase(logic [4:0] mask, logic [CFG_DATA_W-1:0] k_top,
                             logic [CFG_DATA_W-1:0] k_mid, logic [CFG_DATA_W-1:0] k_bot,
                             logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, int n_items,
                             pix_mode_e mode, bit squeeze);
        settle();
        if (mask[CFG_KERNEL_TOP]) cfg_write(CFG_KERNEL_TOP, k_top);
        if (mask[CFG_KERNEL_MID]) cfg_write(CFG_KERNEL_MID, k_mid);
        if (mask[CFG_KERNEL_BOT]) cfg_write(CFG_KERNEL_BOT, k_bot);
        if (mask[CFG_FRAME_WIDTH]) cfg_write(CFG_FRAME_WIDTH, dim_word(w));
        if (mask[CFG_FRAME_HEIGHT]) cfg_write(CFG_FRAME_HEIGHT, dim_word(h));
        // receiver holds off for a long stretch while pixels keep coming
        if (squeeze) begin
            idle_on  = 1'b0;
            hold_req = 1'b1;
        end
        for (int k = 0; k < n_items; k++) offer_pixel(pick_pixel(mode), 1'b0, 0, '0);
        phases_run++;
    endtask

    // result side: check each taken result, then pick the next stall
    always @(posedge i_clk) begin
        conv_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                note_mismatch("result with none outstanding, filtered", int'(o_filtered), 0);
            end else begin
                want = pending_results.pop_front();
                if (o_filtered !== want.filtered)
                    note_mismatch("filtered", int'(o_filtered), int'(want.filtered));
                if (o_out_row !== want.row)
                    note_mismatch("out_row", int'(o_out_row), int'(want.row));
                if (o_out_col !== want.col)
                    note_mismatch("out_col", int'(o_out_col), int'(want.col));
                if (o_run_last !== want.last)
                    note_mismatch("run_last", int'(o_run_last), int'(want.last));
                if (o_frame_done !== want.frame_done)
                    note_mismatch("frame_done", int'(o_frame_done), int'(want.frame_done));
            end
        end

        if (hold_cnt != 0) begin
            hold_cnt--;
            i_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            stall_left = pick_idle(70, 25);
            i_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    // watchdog on cycles with no request taken on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a request, %0d results outstanding",
                     quiet_cycles, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        int               small_items;
        int               ew;
        int               eh;
        int               n_items;
        logic [4:0]       mask;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        pix_mode_e        mode;

        // local state after reset
        kern_rows[0] = KERNEL_TOP_RST;
        kern_rows[1] = KERNEL_MID_RST;
        kern_rows[2] = KERNEL_BOT_RST;
        width_reg    = DIM_W'(DIM_RST);
        height_reg   = DIM_W'(DIM_RST);
        row_pos      = 0;
        col_pos      = 0;
        for (int s = 0; s < 2; s++) begin
            for (int c = 0; c < MAX_WIDTH; c++) line_mem[s][c] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) win[i][j] = '0;
        end
        small_items = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default 3x3 frame with the reset kernel; the top row releases nothing
        add_typed(8'h00, 0, 0, 0, 0, 1'b0);
        add_typed(8'hFF, 0, 0, 0, 0, 1'b0);
        add_typed(8'h55, 0, 0, 0, 0, 1'b0);
        add_pixel(8'hAA);
        add_pixel(8'hFF);
        // writes past the register list leave the frame running
        add_cfg(CFG_UNUSED_LO, 24'hFFFFFF);
        add_cfg(CFG_UNUSED_HI, 24'h000000);
        add_pixel(8'h01);
        add_pixel(8'h80);
        add_pixel(8'hFF);
        add_pixel(8'h7F);
        // zero size acts as a 1x1 frame: centre coefficient times the pixel
        add_cfg(CFG_FRAME_WIDTH, 24'h000000);
        add_cfg(CFG_FRAME_HEIGHT, 24'h000000);
        add_cfg(CFG_KERNEL_MID, 24'h008000);
        add_typed(8'hFF, 1, -32640, 0, 0, 1'b1);
        add_typed(8'h00, 1, 0, 0, 0, 1'b1);
        add_cfg(CFG_KERNEL_MID, 24'h007F00);
        add_typed(8'hFF, 1, 32385, 0, 0, 1'b1);
        // full positive kernel on a flat white frame, after a mid-frame restart
        add_cfg(CFG_KERNEL_TOP, 24'h7F7F7F);
        add_cfg(CFG_KERNEL_MID, 24'h7F7F7F);
        add_cfg(CFG_KERNEL_BOT, 24'h7F7F7F);
        add_cfg(CFG_FRAME_WIDTH, 24'h000003);
        add_cfg(CFG_FRAME_HEIGHT, 24'h000003);
        add_pixel(8'h12);
        add_pixel(8'h34);
        add_cfg(CFG_FRAME_HEIGHT, 24'h000003);
        for (int k = 0; k < 9; k++) add_pixel(8'hFF);

        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CFG) begin
                settle();
                cfg_write(stim_table[i].idx, stim_table[i].data);
            end else begin
                offer_pixel(stim_table[i].px, stim_table[i].typed, stim_table[i].n_typed,
                            stim_table[i].res);
            end
        end

        // most negative sum on a white frame
        run_phase(5'b11111, 24'h808080, 24'h808080, 24'h808080, 11'd3, 11'd3, 9,
                  PIX_FULL, 1'b0);
        // oversize width clamps to the maximum; one full row and a bit more
        run_phase(5'b11000, '0, '0, '0, 11'h7FF, 11'd1, MAX_WIDTH + 6, PIX_ANY, 1'b0);
        // oversize height clamps to the maximum
        run_phase(5'b11000, '0, '0, '0, 11'd1, 11'h7FF, MAX_HEIGHT + 6, PIX_ANY, 1'b0);
        // back pressure: short frame whose last row releases many results
        run_phase(5'b11111, pick_kernel(), pick_kernel(), pick_kernel(), 11'd3, 11'd2, 40,
                  PIX_ANY, 1'b1);

        // small random settings
        while (small_items < SMALL_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
                settle();
                cfg_write(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                          CFG_DATA_W'($urandom));
            end
            mask = 5'($urandom);
            if ($urandom_range(0, 9) < 6) begin
                mask[CFG_FRAME_WIDTH]  = 1'b1;
                mask[CFG_FRAME_HEIGHT] = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) w = '0;
            else w = DIM_W'($urandom_range(1, 8));
            if ($urandom_range(0, 9) == 0) h = '0;
            else h = DIM_W'($urandom_range(1, 6));
            case ($urandom_range(0, 5))
                0:       mode = PIX_EDGE;
                1:       mode = PIX_FULL;
                default: mode = PIX_ANY;
            endcase
            ew = eff_dim(mask[CFG_FRAME_WIDTH] ? w : width_reg, MAX_WIDTH);
            eh = eff_dim(mask[CFG_FRAME_HEIGHT] ? h : height_reg, MAX_HEIGHT);
            n_items = ew * eh * $urandom_range(1, 2) + $urandom_range(0, ew);
            if (n_items > 60) n_items = 60;
            run_phase(mask, pick_kernel(), pick_kernel(), pick_kernel(), w, h, n_items, mode,
                      1'b0);
            small_items += n_items;
        end

        // drain and let the pipe run empty
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);

        $display("run covered %0d pixels over %0d settings, %0d register writes, %0d results",
                 pixels_sent, phases_run, cfg_writes, results_seen);
        $display("frames from 1x1 to clamped width and height, kernel extremes, receiver hold-off");
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
